// File: hdl/stpg_pkg.sv
`default_nettype none
package stpg_pkg;

  // Field widths
  localparam int STEP_W    = 17;
  localparam int PERIOD_W  = 16;
  localparam int RAMP_W    = 16;
  localparam int HALF_W    = 15;
  localparam int IN_DATA_W = 40;   // step_count + cruise_period, padded to bytes
  localparam int OUT_DATA_W = 8;   // four result flags, padded to a byte
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // Serial divider
  localparam int DIV_DVD_W = 32;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD = 1'b1;

  localparam logic [RAMP_W-1:0]   RAMP_LIMIT_RST  = 16'd450;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd5000;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD      = 16'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic update;      // apply the start or the tick
    logic prep;        // begin a step at cruise period if no divide is needed
    logic div_start;   // launch the ramp divide
    logic div_finish;  // begin a step from the divide result
    logic out_load;    // capture the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } status_t;

  // Half period of a step: period/2, never less than one tick
  function automatic logic [HALF_W-1:0] half_of(input logic [PERIOD_W-1:0] period);
    logic [HALF_W-1:0] h;
    h = period[PERIOD_W-1:1];
    return (h == '0) ? HALF_W'(1) : h;
  endfunction

endpackage
`default_nettype wire

// File: hdl/stpg_div.sv
`default_nettype none
module stpg_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [stpg_pkg::DIV_DVD_W-1:0]   dividend,
  input  wire logic [stpg_pkg::RAMP_W-1:0]      divisor,
  output logic                                  done,
  output logic [stpg_pkg::PERIOD_W-1:0]         quotient
);
  import stpg_pkg::*;

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DVD_W-1:0] dvd;
  logic [RAMP_W-1:0]    rem;
  logic [RAMP_W:0]      rem_sh;
  logic                 fits;
  logic [RAMP_W-1:0]    rem_next;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, dvd[DIV_DVD_W-1]};
    fits     = rem_sh >= {1'b0, divisor};
    rem_next = fits ? RAMP_W'(rem_sh - {1'b0, divisor}) : rem_sh[RAMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[DIV_DVD_W-2:0], fits};
      rem <= rem_next;
    end
  end

  // The quotient never exceeds the span, so the low half holds it
  assign quotient = dvd[PERIOD_W-1:0];

endmodule
`default_nettype wire

// File: hdl/stpg_dp.sv
`default_nettype none
module stpg_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire stpg_pkg::cmd_t                    cmd,
  output stpg_pkg::status_t                      status,
  input  wire logic                              in_kind,
  input  wire logic [stpg_pkg::STEP_W-1:0]       in_step_count,
  input  wire logic [stpg_pkg::PERIOD_W-1:0]     in_cruise_period,
  input  wire logic                              cfg_write,
  input  wire logic [stpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stpg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [stpg_pkg::OUT_DATA_W-1:0]        out_data
);
  import stpg_pkg::*;

  // Configuration
  logic [RAMP_W-1:0]   ramp_limit;
  logic [PERIOD_W-1:0] slow_period;

  // Latched item
  logic                kind;
  logic [STEP_W-1:0]   step_count;
  logic [PERIOD_W-1:0] cruise_period;

  // Move state
  phase_t              phase;
  logic                dir_out;
  logic [RAMP_W-1:0]   ramp_len;
  logic [STEP_W-1:0]   cruise_len;
  logic [STEP_W-1:0]   step_index;
  logic [PERIOD_W-1:0] cruise_ticks;
  logic [HALF_W-1:0]   half_len;
  logic [HALF_W-1:0]   tick_count;
  logic                pin_level;
  logic                done;
  logic                need_step;

  logic [PERIOD_W-1:0] slow;
  logic                neg;
  logic [STEP_W:0]     n_abs;
  logic [STEP_W-1:0]   half_n;
  logic [RAMP_W-1:0]   ramp_sel;
  logic [PERIOD_W-1:0] cp_sat;
  logic [HALF_W-1:0]   tick_inc;
  logic [STEP_W-1:0]   step_inc;
  logic                on_ramp;
  logic [PERIOD_W-1:0] span;
  logic [DIV_DVD_W-1:0] product;
  logic                div_done;
  logic [PERIOD_W-1:0] quotient;
  logic [PERIOD_W-1:0] div_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_limit  <= RAMP_LIMIT_RST;
      slow_period <= SLOW_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RAMP_LIMIT:  ramp_limit  <= cfg_data;
        REG_SLOW_PERIOD: slow_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind          <= in_kind;
      step_count    <= in_step_count;
      cruise_period <= in_cruise_period;
    end
  end

  always_comb begin
    slow     = (slow_period < MIN_PERIOD) ? MIN_PERIOD : slow_period;
    neg      = step_count[STEP_W-1];
    n_abs    = neg ? ((STEP_W+1)'(1) << STEP_W) - {1'b0, step_count} : {1'b0, step_count};
    half_n   = n_abs[STEP_W:1];
    ramp_sel = ({1'b0, ramp_limit} < half_n) ? ramp_limit : half_n[RAMP_W-1:0];
    if (cruise_period < MIN_PERIOD) begin
      cp_sat = MIN_PERIOD;
    end else if (cruise_period > slow) begin
      cp_sat = slow;
    end else begin
      cp_sat = cruise_period;
    end
    tick_inc  = tick_count + HALF_W'(1);
    step_inc  = step_index + STEP_W'(1);
    // Ramp steps take a divided period; cruise steps and flat ramps do not
    on_ramp   = (phase != PH_CRUISE) && (ramp_len != '0) && (slow > cruise_ticks);
    span      = slow - cruise_ticks;
    product   = DIV_DVD_W'(span) * DIV_DVD_W'(step_index[RAMP_W-1:0]);
    div_period = (phase == PH_ACCEL) ? (slow - quotient) : (cruise_ticks + quotient);
  end

  stpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (ramp_len),
    .done     (div_done),
    .quotient (quotient)
  );

  assign status.need_div = need_step && on_ramp;
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      dir_out      <= 1'b0;
      ramp_len     <= '0;
      cruise_len   <= '0;
      step_index   <= '0;
      cruise_ticks <= '0;
      half_len     <= '0;
      tick_count   <= '0;
      pin_level    <= 1'b0;
      done         <= 1'b0;
      need_step    <= 1'b0;
    end else begin
      if (cmd.update) begin
        done      <= 1'b0;
        need_step <= 1'b0;
        if (kind) begin
          dir_out      <= !neg && (step_count != '0);
          cruise_ticks <= cp_sat;
          ramp_len     <= ramp_sel;
          cruise_len   <= n_abs[STEP_W-1:0] - {ramp_sel, 1'b0};
          step_index   <= '0;
          tick_count   <= '0;
          pin_level    <= 1'b0;
          half_len     <= '0;
          if (n_abs == '0) begin
            phase <= PH_IDLE;
          end else begin
            phase     <= (ramp_sel != '0) ? PH_ACCEL : PH_CRUISE;
            need_step <= 1'b1;
          end
        end else if (phase != PH_IDLE) begin
          if (tick_inc >= half_len) begin
            tick_count <= '0;
            if (pin_level) begin
              pin_level <= 1'b0;
            end else begin
              // Advance to the next step and maybe the next phase
              step_index <= step_inc;
              need_step  <= 1'b1;
              case (phase)
                PH_ACCEL: begin
                  if (step_inc >= {1'b0, ramp_len}) begin
                    step_index <= '0;
                    phase      <= (cruise_len != '0) ? PH_CRUISE : PH_DECEL;
                  end
                end
                PH_CRUISE: begin
                  if (step_inc >= cruise_len) begin
                    step_index <= '0;
                    if (ramp_len == '0) begin
                      phase     <= PH_IDLE;
                      done      <= 1'b1;
                      need_step <= 1'b0;
                    end else begin
                      phase <= PH_DECEL;
                    end
                  end
                end
                PH_DECEL: begin
                  if (step_inc >= {1'b0, ramp_len}) begin
                    step_index <= '0;
                    phase      <= PH_IDLE;
                    done       <= 1'b1;
                    need_step  <= 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end else begin
            tick_count <= tick_inc;
          end
        end
      end

      if (cmd.prep && need_step && !on_ramp) begin
        half_len   <= half_of(cruise_ticks);
        tick_count <= '0;
        pin_level  <= 1'b1;
      end

      if (cmd.div_finish) begin
        half_len   <= half_of(div_period);
        tick_count <= '0;
        pin_level  <= 1'b1;
      end
    end
  end

  // Result byte: step_level, direction, busy_res, done_res from bit 0 up
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {4'b0000, done, (phase != PH_IDLE), dir_out, pin_level};
    end
  end

endmodule
`default_nettype wire

// File: hdl/stpg_ctrl.sv
`default_nettype none
module stpg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire stpg_pkg::status_t   status,
  output stpg_pkg::cmd_t           cmd
);
  import stpg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_PREP   = 5'b00100,
    S_DIV    = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.update     = (state == S_UPDATE);
    cmd.prep       = (state == S_PREP);
    cmd.div_start  = (state == S_PREP) && status.need_div;
    cmd.div_finish = (state == S_DIV) && status.div_done;
    cmd.out_load   = (state == S_FIN) && out_free;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_UPDATE;
      S_UPDATE: state_next = S_PREP;
      S_PREP:   state_next = status.need_div ? S_DIV : S_FIN;
      S_DIV:    if (status.div_done) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/stepper_trapezoid_pulse_generator.sv
`default_nettype none
// Channel  Direction  Handshake                Payload
// s_       in         s_tvalid / s_tready      s_tdata, s_tuser (item: start or tick)
// m_       out        m_tvalid / m_tready      m_tdata (one result per item)
// cfg_     in         cfg_valid / cfg_ready    cfg_index, cfg_data (register write)
//
// An item that begins no ramp step passes through accept, update, prep and
// result load; result load registers its result and sets m_tvalid.
// A step that starts on a ramp adds the serial divider between prep and result
// load; cruise steps skip the divider.
// Reset is synchronous; configuration and move state load at once.
// A result waits in the output register while the next item is accepted;
// that item stalls only at its own result until the register empties.
module stepper_trapezoid_pulse_generator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // s_tdata: step_count[16:0], cruise_period[32:17], zero pad [39:33]
  input  wire logic [stpg_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: kind (0 timer tick, 1 start a move)
  input  wire logic                              s_tuser,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // m_tdata: step_level[0], direction[1], busy_res[2], done_res[3], zero pad [7:4]
  output logic [stpg_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [stpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stpg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import stpg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  stpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Split the item fields out of the packed bus
  stpg_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_kind          (s_tuser),
    .in_step_count    (s_tdata[STEP_W-1:0]),
    .in_cruise_period (s_tdata[STEP_W+PERIOD_W-1:STEP_W]),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_data         (m_tdata)
  );

endmodule
`default_nettype wire
